// File: hw/rtl/pcd_pkg.sv
// shared constants and codes for the persistent congestion detector
`default_nettype none

package pcd_pkg;

    localparam int TX_TIME_W   = 63;
    localparam int COUNT_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SRTT_W      = 32;
    localparam int RTTVAR_W    = 32;
    localparam int THRESH_W    = 8;
    localparam int GRAN_W      = 16;
    localparam int PTO_W       = 35;
    localparam int PERIOD_W    = 43;
    localparam int PERIOD_NS_W = 53;
    localparam int SEEN_W      = 2;

    localparam logic [SEEN_W-1:0] SEEN_SAT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SRTT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RTTVAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RTT_VALID = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAN      = 3'd4;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd3;
    localparam logic [GRAN_W-1:0]   GRAN_RESET   = 16'd1000;

    localparam logic [STATUS_W-1:0] ST_DETECTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW_PKTS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RTT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_PERIOD = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT       = 3'd4;

endpackage

`default_nettype wire

// File: hw/rtl/pcd_if.sv
// handshake interfaces for lost packet items, verdict items and register writes
`default_nettype none

interface pcd_pkt_if;
    import pcd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TX_TIME_W-1:0] tx_time_ns;
    logic                 elicit_ack;
    logic                 last_in_batch;
    modport source(output valid, tx_time_ns, elicit_ack, last_in_batch, input ready);
    modport sink(input valid, tx_time_ns, elicit_ack, last_in_batch, output ready);
endinterface

interface pcd_res_if;
    import pcd_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] batch_status;
    logic                congestion_declared;
    logic [COUNT_W-1:0]  detections_total;
    modport source(output valid, batch_status, congestion_declared, detections_total,
                   input ready);
    modport sink(input valid, batch_status, congestion_declared, detections_total,
                 output ready);
endinterface

interface pcd_cfg_if;
    import pcd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/persistent_congestion_detector_core.sv
// persistent congestion detector: min/max span tracking over lost packet batches
// Takes one lost packet item per clock while no last packet is stalled. Packets that
// are not last in their batch give no result; the last packet gives one verdict item
// after it is accepted (input register, batch close, span subtract, compare into
// the output register). The span test is done in nanoseconds against period * 1000,
// which matches the truncated microsecond compare. The period is derived from the
// registers through a three-register chain, so a register write takes effect for
// items accepted from the next cycle on. A stalled verdict holds only the stages
// behind it that also carry a verdict; non-final packets keep flowing.
`default_nettype none

module persistent_congestion_detector_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcd_pkt_if.sink   i_pkt,
    pcd_res_if.source o_res,
    pcd_cfg_if.sink   i_cfg
);
    import pcd_pkg::*;

    // configuration
    logic [SRTT_W-1:0]   r_srtt;
    logic [RTTVAR_W-1:0] r_rttvar;
    logic                r_rtt_valid;
    logic [THRESH_W-1:0] r_thresh;
    logic [GRAN_W-1:0]   r_gran;

    // derived period
    logic [RTTVAR_W+1:0]    n_var4;
    logic [PTO_W-1:0]       n_pto;
    logic [PTO_W-1:0]       r_pto;
    logic [PERIOD_W-1:0]    r_period;
    logic [PERIOD_NS_W-1:0] r_period_ns;

    // handshake
    logic out_free, d_move, d_free, c_move, c_free, a_move, a_free, in_acc;

    // input stage
    logic                 r_a_valid;
    logic [TX_TIME_W-1:0] r_a_time;
    logic                 r_a_elic;
    logic                 r_a_last;

    // open batch
    logic [TX_TIME_W-1:0] r_early, r_late, n_early, n_late;
    logic [SEEN_W-1:0]    r_pkt_cnt, r_elic_cnt, n_pkt_cnt, n_elic_cnt;

    // closed batch
    logic                 r_c_valid;
    logic [TX_TIME_W-1:0] r_c_early, r_c_late;
    logic [SEEN_W-1:0]    r_c_pkt_cnt, r_c_elic_cnt;

    // span stage
    logic                 r_d_valid;
    logic [TX_TIME_W-1:0] r_d_span;
    logic                 r_d_few_pkts, r_d_few_elic;

    // verdict
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_status;
    logic                r_out_declared;
    logic [COUNT_W-1:0]  r_out_total, r_cnt, n_cnt;
    logic                span_long;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srtt      <= '0;
            r_rttvar    <= '0;
            r_rtt_valid <= 1'b0;
            r_thresh    <= THRESH_RESET;
            r_gran      <= GRAN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SRTT:      r_srtt      <= i_cfg.data[SRTT_W-1:0];
                REG_RTTVAR:    r_rttvar    <= i_cfg.data[RTTVAR_W-1:0];
                REG_RTT_VALID: r_rtt_valid <= i_cfg.data[0];
                REG_THRESH:    r_thresh    <= i_cfg.data[THRESH_W-1:0];
                REG_GRAN:      r_gran      <= i_cfg.data[GRAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_var4 = {r_rttvar, 2'b00};
        if (n_var4 > (RTTVAR_W+2)'(r_gran)) begin
            n_pto = PTO_W'(r_srtt) + PTO_W'(n_var4);
        end else begin
            n_pto = PTO_W'(r_srtt) + PTO_W'(r_gran);
        end
    end

    // period * 1000 = (p << 10) - (p << 4) - (p << 3)
    always_ff @(posedge i_clk) begin
        r_pto       <= n_pto;
        r_period    <= PERIOD_W'(r_pto) * PERIOD_W'(r_thresh);
        r_period_ns <= {r_period, 10'b0} - PERIOD_NS_W'({r_period, 4'b0})
                       - PERIOD_NS_W'({r_period, 3'b0});
    end

    assign out_free = !r_out_valid || o_res.ready;
    assign d_move   = r_d_valid && out_free;
    assign d_free   = !r_d_valid || d_move;
    assign c_move   = r_c_valid && d_free;
    assign c_free   = !r_c_valid || c_move;
    assign a_move   = r_a_valid && (!r_a_last || c_free);
    assign a_free   = !r_a_valid || a_move;
    assign in_acc   = i_pkt.valid && a_free;

    assign i_pkt.ready = a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_pkt.valid;
        end
        if (in_acc) begin
            r_a_time <= i_pkt.tx_time_ns;
            r_a_elic <= i_pkt.elicit_ack;
            r_a_last <= i_pkt.last_in_batch;
        end
    end

    always_comb begin
        n_early    = r_early;
        n_late     = r_late;
        n_elic_cnt = r_elic_cnt;
        n_pkt_cnt  = (r_pkt_cnt < SEEN_SAT) ? r_pkt_cnt + 2'd1 : r_pkt_cnt;
        if (r_a_elic) begin
            if (r_elic_cnt == '0) begin
                n_early = r_a_time;
                n_late  = r_a_time;
            end else begin
                if (r_a_time < r_early) begin
                    n_early = r_a_time;
                end
                if (r_a_time > r_late) begin
                    n_late = r_a_time;
                end
            end
            if (r_elic_cnt < SEEN_SAT) begin
                n_elic_cnt = r_elic_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_early    <= '0;
            r_late     <= '0;
            r_pkt_cnt  <= '0;
            r_elic_cnt <= '0;
        end else if (a_move) begin
            if (r_a_last) begin
                r_early    <= '0;
                r_late     <= '0;
                r_pkt_cnt  <= '0;
                r_elic_cnt <= '0;
            end else begin
                r_early    <= n_early;
                r_late     <= n_late;
                r_pkt_cnt  <= n_pkt_cnt;
                r_elic_cnt <= n_elic_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= a_move && r_a_last;
        end
        if (c_free && a_move && r_a_last) begin
            r_c_early    <= n_early;
            r_c_late     <= n_late;
            r_c_pkt_cnt  <= n_pkt_cnt;
            r_c_elic_cnt <= n_elic_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_free) begin
            r_d_valid <= c_move;
        end
        if (c_move) begin
            r_d_span     <= r_c_late - r_c_early;
            r_d_few_pkts <= r_c_pkt_cnt < SEEN_SAT;
            r_d_few_elic <= r_c_elic_cnt < SEEN_SAT;
        end
    end

    assign span_long = r_d_span >= TX_TIME_W'(r_period_ns);

    always_comb begin
        if (r_d_few_pkts) begin
            n_status = ST_FEW_PKTS;
        end else if (!r_rtt_valid) begin
            n_status = ST_NO_RTT;
        end else if (r_period == '0) begin
            n_status = ST_ZERO_PERIOD;
        end else if (r_d_few_elic || !span_long) begin
            n_status = ST_SHORT;
        end else begin
            n_status = ST_DETECTED;
        end
        n_cnt = r_cnt;
        if (n_status == ST_DETECTED && r_cnt != '1) begin
            n_cnt = r_cnt + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= d_move;
            end
            if (d_move) begin
                r_cnt <= n_cnt;
            end
        end
        if (d_move) begin
            r_out_status   <= n_status;
            r_out_declared <= n_status == ST_DETECTED;
            r_out_total    <= n_cnt;
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.batch_status        = r_out_status;
    assign o_res.congestion_declared = r_out_declared;
    assign o_res.detections_total    = r_out_total;

endmodule

`default_nettype wire
